@@ rtl/pm25aqi_pkg.sv @@
// Shared constants, segment tables and types for the PM2.5 index block.
package pm25aqi_pkg;

  localparam int CONC_W      = 16;
  localparam int IDX_W       = 9;
  localparam int CAT_W       = 3;
  localparam int SEG_COUNT   = 7;
  localparam int SEG_IDX_W   = $clog2(SEG_COUNT);
  localparam int DIFF_W      = 11;
  localparam int NUM_W       = 13;
  localparam int QUO_W       = 7;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 22;
  localparam int MUL_A_W     = 4;
  localparam int MUL_B_W     = 6;

  localparam logic [CONC_W-1:0] TOP_TENTHS = CONC_W'(5505);

  // Lower breakpoint of each segment in tenths of a microgram per cubic meter.
  localparam logic [CONC_W-1:0] SEG_LO [SEG_COUNT] = '{
    CONC_W'(0), CONC_W'(120), CONC_W'(355), CONC_W'(555),
    CONC_W'(1505), CONC_W'(2505), CONC_W'(3505)
  };

  // The slope span/width of each segment reduced to a/b; the quotient is
  // floor((2*d*a + b) / (2*b)) with d the offset into the segment.
  localparam logic [MUL_A_W-1:0] SEG_A [SEG_COUNT] = '{
    MUL_A_W'(5), MUL_A_W'(10), MUL_A_W'(1), MUL_A_W'(1),
    MUL_A_W'(1), MUL_A_W'(1), MUL_A_W'(1)
  };
  localparam logic [MUL_B_W-1:0] SEG_B [SEG_COUNT] = '{
    MUL_B_W'(12), MUL_B_W'(47), MUL_B_W'(4), MUL_B_W'(19),
    MUL_B_W'(10), MUL_B_W'(10), MUL_B_W'(20)
  };

  // Rounded-up reciprocals of 2*b, scaled by 2**RECIP_SHIFT. The rounding
  // error times the largest numerator stays below 2**RECIP_SHIFT, so the
  // truncated product is the exact quotient.
  localparam logic [RECIP_W-1:0] SEG_RECIP [SEG_COUNT] = '{
    RECIP_W'(((1 << RECIP_SHIFT) + 23) / 24),
    RECIP_W'(((1 << RECIP_SHIFT) + 93) / 94),
    RECIP_W'(((1 << RECIP_SHIFT) + 7) / 8),
    RECIP_W'(((1 << RECIP_SHIFT) + 37) / 38),
    RECIP_W'(((1 << RECIP_SHIFT) + 19) / 20),
    RECIP_W'(((1 << RECIP_SHIFT) + 19) / 20),
    RECIP_W'(((1 << RECIP_SHIFT) + 39) / 40)
  };

  localparam logic [IDX_W-1:0] SEG_ILO [SEG_COUNT] = '{
    IDX_W'(0), IDX_W'(50), IDX_W'(100), IDX_W'(150),
    IDX_W'(200), IDX_W'(300), IDX_W'(400)
  };

  localparam logic [CAT_W-1:0] CAT_GOOD      = CAT_W'(0);
  localparam logic [CAT_W-1:0] CAT_MODERATE  = CAT_W'(1);
  localparam logic [CAT_W-1:0] CAT_SLIGHT    = CAT_W'(2);
  localparam logic [CAT_W-1:0] CAT_UNHEALTHY = CAT_W'(3);
  localparam logic [CAT_W-1:0] CAT_VERY      = CAT_W'(4);
  localparam logic [CAT_W-1:0] CAT_HAZARDOUS = CAT_W'(5);
  localparam logic [CAT_W-1:0] CAT_EXTREME   = CAT_W'(6);
  localparam logic [CAT_W-1:0] CAT_UNKNOWN   = CAT_W'(7);

  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(500);

  typedef struct packed {
    logic                 oor;
    logic [SEG_IDX_W-1:0] seg;
    logic [NUM_W-1:0]     num;
  } seg_t;

endpackage

@@ rtl/pm25aqi_seg.sv @@
// Segment lookup and rounding numerator for one concentration sample.
module pm25aqi_seg (
  input  logic [pm25aqi_pkg::CONC_W-1:0] conc,
  output pm25aqi_pkg::seg_t              seg_info
);

  logic [pm25aqi_pkg::SEG_IDX_W-1:0] seg;
  logic [pm25aqi_pkg::CONC_W-1:0]    offset;
  logic [pm25aqi_pkg::NUM_W-1:0]     diff;

  always_comb begin
    // Exactly 12.0 still belongs to the first segment.
    seg = '0;
    if (conc > pm25aqi_pkg::SEG_LO[1]) begin
      seg = pm25aqi_pkg::SEG_IDX_W'(1);
    end
    for (int k = 2; k < pm25aqi_pkg::SEG_COUNT; k++) begin
      if (conc >= pm25aqi_pkg::SEG_LO[k]) begin
        seg = pm25aqi_pkg::SEG_IDX_W'(k);
      end
    end
  end

  assign offset = conc - pm25aqi_pkg::SEG_LO[seg];
  assign diff   = pm25aqi_pkg::NUM_W'(offset[pm25aqi_pkg::DIFF_W-1:0]);

  assign seg_info.oor = (conc > pm25aqi_pkg::TOP_TENTHS);
  assign seg_info.seg = seg;
  assign seg_info.num = pm25aqi_pkg::NUM_W'((diff << 1) * pm25aqi_pkg::SEG_A[seg]
                        + pm25aqi_pkg::SEG_B[seg]);

endmodule

@@ rtl/pm25aqi_scale.sv @@
// Reciprocal scaling of the numerator, index assembly and category banding.
module pm25aqi_scale (
  input  pm25aqi_pkg::seg_t               seg_info,
  output logic [pm25aqi_pkg::IDX_W-1:0]   index_value,
  output logic [pm25aqi_pkg::CAT_W-1:0]   category,
  output logic                            out_of_range
);

  localparam int PROD_W = pm25aqi_pkg::NUM_W + pm25aqi_pkg::RECIP_W;

  logic [PROD_W-1:0]               prod;
  logic [pm25aqi_pkg::QUO_W-1:0]   quo;
  logic [pm25aqi_pkg::IDX_W-1:0]   idx;

  assign prod = PROD_W'(seg_info.num) * PROD_W'(pm25aqi_pkg::SEG_RECIP[seg_info.seg]);
  assign quo  = prod[pm25aqi_pkg::RECIP_SHIFT +: pm25aqi_pkg::QUO_W];
  assign idx  = pm25aqi_pkg::SEG_ILO[seg_info.seg] + pm25aqi_pkg::IDX_W'(quo);

  always_comb begin
    out_of_range = seg_info.oor;
    index_value  = idx;
    if (seg_info.oor) begin
      index_value = '0;
      category    = pm25aqi_pkg::CAT_UNKNOWN;
    end else if (idx < pm25aqi_pkg::IDX_W'(50)) begin
      category = pm25aqi_pkg::CAT_GOOD;
    end else if (idx < pm25aqi_pkg::IDX_W'(100)) begin
      category = pm25aqi_pkg::CAT_MODERATE;
    end else if (idx < pm25aqi_pkg::IDX_W'(150)) begin
      category = pm25aqi_pkg::CAT_SLIGHT;
    end else if (idx < pm25aqi_pkg::IDX_W'(200)) begin
      category = pm25aqi_pkg::CAT_UNHEALTHY;
    end else if (idx < pm25aqi_pkg::IDX_W'(300)) begin
      category = pm25aqi_pkg::CAT_VERY;
    end else if (idx < pm25aqi_pkg::IDX_W'(400)) begin
      category = pm25aqi_pkg::CAT_HAZARDOUS;
    end else begin
      category = pm25aqi_pkg::CAT_EXTREME;
    end
  end

endmodule

@@ rtl/pm25_aqi_and_category.sv @@
// PM2.5 concentration to air quality index and category, three register stages.
// Takes one concentration beat per cycle while the output side is not stalled
// and returns its index, category and out-of-range flag after it passes the
// input register, the segment/numerator register and the result register.
// Each stage holds when the one after it is full and not draining, so up to
// three beats are held inside while the output is stalled, and the input
// stalls only once all three stages are full.
module pm25_aqi_and_category (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pm25aqi_pkg::CONC_W-1:0]  concentration_tenths,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pm25aqi_pkg::IDX_W-1:0]   index_value,
  output logic [pm25aqi_pkg::CAT_W-1:0]   category,
  output logic                            out_of_range
);

  logic                           v1;
  logic                           v2;
  logic                           v3;
  logic                           en1;
  logic                           en2;
  logic                           en3;
  logic [pm25aqi_pkg::CONC_W-1:0] conc;
  pm25aqi_pkg::seg_t              seg_next;
  pm25aqi_pkg::seg_t              seg_reg;
  logic [pm25aqi_pkg::IDX_W-1:0]  index_next;
  logic [pm25aqi_pkg::CAT_W-1:0]  category_next;
  logic                           oor_next;

  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) conc <= concentration_tenths;
    if (en2 && v1) seg_reg <= seg_next;
    if (en3 && v2) begin
      index_value  <= index_next;
      category     <= category_next;
      out_of_range <= oor_next;
    end
  end

  pm25aqi_seg u_seg (
    .conc     (conc),
    .seg_info (seg_next)
  );

  pm25aqi_scale u_scale (
    .seg_info     (seg_reg),
    .index_value  (index_next),
    .category     (category_next),
    .out_of_range (oor_next)
  );

  assign out_valid = v3;

endmodule

@@ rtl/pm25aqi_checker.sv @@
// Port-level checks of the PM2.5 index block, bound to the top level.
module pm25aqi_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [pm25aqi_pkg::IDX_W-1:0]  index_value,
  input logic [pm25aqi_pkg::CAT_W-1:0]  category,
  input logic                           out_of_range
);

  // A stalled result beat keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(index_value) &&
      $stable(category) && $stable(out_of_range))
    else $error("result beat changed while stalled");

  a_oor: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |->
      index_value == '0 && category == pm25aqi_pkg::CAT_UNKNOWN)
    else $error("out-of-range beat carries an index or category");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_of_range |->
      index_value <= pm25aqi_pkg::IDX_MAX && category != pm25aqi_pkg::CAT_UNKNOWN)
    else $error("in-range beat has an impossible index or category");

  a_band: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_of_range && index_value < pm25aqi_pkg::IDX_W'(50) |->
      category == pm25aqi_pkg::CAT_GOOD)
    else $error("low index not banded as good");

  // The pipeline is empty on the first cycle after reset.
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result beat shown right after reset");

endmodule

bind pm25_aqi_and_category pm25aqi_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .index_value  (index_value),
  .category     (category),
  .out_of_range (out_of_range)
);
